// ----- design/pidmd_pkg.sv -----
// pidmd_pkg: shared types and constants for the PID unit with minimum drive and clamps.
// No dependencies; used by the drive channel interface and the top level.
`default_nettype none

package pidmd_pkg;

  // Fixed field widths
  localparam int GAIN_WIDTH  = 24;
  localparam int LIMIT_WIDTH = 15;
  localparam int SPEED_WIDTH = 8;
  localparam int INTEG_WIDTH = 32;
  localparam int DRIVE_WIDTH = 16;
  localparam int CFG_IDX_W   = 3;

  // Integration only proceeds while the running sum is below this
  localparam logic signed [INTEG_WIDTH-1:0] INTEG_WINDUP_MAX = 32'sd10000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_INTEG_LIMIT   = 3'd3,
    REG_INTEG_CLAMP   = 3'd4,
    REG_OUTPUT_CLAMP  = 3'd5,
    REG_MIN_SPEED     = 3'd6,
    REG_MIN_VALID     = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/pidmd_if.sv -----
// pidmd_if: valid/ready channel interfaces for sample beats and drive results.
// Depends on pidmd_pkg for the drive width.
`default_nettype none

interface pidmd_in_if #(
  parameter int MEAS_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [MEAS_WIDTH-1:0] target;
  logic signed [MEAS_WIDTH-1:0] measurement;
  logic                         clear_state;

  modport source (output valid, target, measurement, clear_state, input ready);
  modport sink   (input valid, target, measurement, clear_state, output ready);
endinterface

interface pidmd_out_if
  import pidmd_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [DRIVE_WIDTH-1:0] drive;
  logic                          sensor_invalid;
  logic                          output_limited;

  modport source (output valid, drive, sensor_invalid, output_limited, input ready);
  modport sink   (input valid, drive, sensor_invalid, output_limited, output ready);
endinterface

`default_nettype wire

// ----- design/pid_with_min_drive_and_clamps_unit.sv -----
// PID controller with integral windup limit, minimum drive and output clamps.
// Every sample beat on in_ch returns one result beat on out_ch, in order.
// Channels: in_ch carries target, measurement and clear_state; out_ch carries
// drive, sensor_invalid and output_limited. Both use valid/ready; a beat moves
// when both are high.
// Configuration: cfg_we writes cfg_wdata into the register picked by cfg_addr
// (gains, windup limit, clamps, minimum speed, minimum valid measurement).
// Write only while no beat is in flight.
// Pipeline: the input register is followed by the state-update operand register,
// the gain multiplier register and the sum/limit stage into the output register.
// Throughput: one beat per cycle while out_ch is ready; the integral and previous
// error update loops via one state-stage register, so beats follow back to back.
// Stalls: each stage holds its beat only while the stage after it is full,
// so in_ch.ready stays high until every stage is occupied.
// Reset (rst_n low, synchronous): pipeline empties, integral and previous
// error clear, registers return to their reset values.
`default_nettype none

module pid_with_min_drive_and_clamps_unit
  import pidmd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int MEAS_WIDTH     = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [((MEAS_WIDTH > GAIN_WIDTH) ? MEAS_WIDTH : GAIN_WIDTH)-1:0] cfg_wdata,
  pidmd_in_if.sink                    in_ch,
  pidmd_out_if.source                 out_ch
);

  localparam int ERR_W = MEAS_WIDTH + 1;
  localparam int DER_W = MEAS_WIDTH + 2;
  localparam int PP_W  = ERR_W + GAIN_WIDTH + 1;
  localparam int PI_W  = INTEG_WIDTH + GAIN_WIDTH + 1;
  localparam int PD_W  = DER_W + GAIN_WIDTH + 1;
  localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
  localparam int MAG_W = SUM_W - GAIN_FRAC_BITS;
  localparam int SAT_W = DRIVE_WIDTH + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [GAIN_WIDTH-1:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_WIDTH-1:0]       integ_limit_r, integ_clamp_r, output_clamp_r;
  logic [SPEED_WIDTH-1:0]       min_speed_r;
  logic signed [MEAS_WIDTH-1:0] min_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= '0;
      gain_i_r       <= '0;
      gain_d_r       <= '0;
      integ_limit_r  <= LIMIT_WIDTH'(100);
      integ_clamp_r  <= '0;
      output_clamp_r <= '0;
      min_speed_r    <= '0;
      min_valid_r    <= {1'b1, {(MEAS_WIDTH-1){1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GAIN_P:       gain_p_r       <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_GAIN_I:       gain_i_r       <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_GAIN_D:       gain_d_r       <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_INTEG_LIMIT:  integ_limit_r  <= cfg_wdata[LIMIT_WIDTH-1:0];
        REG_INTEG_CLAMP:  integ_clamp_r  <= cfg_wdata[LIMIT_WIDTH-1:0];
        REG_OUTPUT_CLAMP: output_clamp_r <= cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MIN_SPEED:    min_speed_r    <= cfg_wdata[SPEED_WIDTH-1:0];
        REG_MIN_VALID:    min_valid_r    <= cfg_wdata[MEAS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic load_o, load3, load2, load1;
  logic adv1;

  assign load_o      = !out_valid_r || out_ch.ready;
  assign load3       = !v3_r || load_o;
  assign load2       = !v2_r || load3;
  assign load1       = !v1_r || load2;
  assign adv1        = v1_r && load2;
  assign in_ch.ready = load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load1)  v1_r        <= in_ch.valid;
      if (load2)  v2_r        <= v1_r;
      if (load3)  v3_r        <= v2_r;
      if (load_o) out_valid_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  logic signed [MEAS_WIDTH-1:0] tgt_r, meas_r;
  logic                         clr_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      tgt_r  <= in_ch.target;
      meas_r <= in_ch.measurement;
      clr_r  <= in_ch.clear_state;
    end
  end

  // ---------------------------------------------------------------------
  // State update: error, windup-limited integral, derivative
  logic signed [INTEG_WIDTH-1:0] integ_sum_r, integ_nxt, integ_new;
  logic signed [ERR_W-1:0]       prev_err_r, prev_err_nxt;
  logic signed [ERR_W-1:0]       err_c;
  logic [ERR_W-1:0]              abs_err;
  logic signed [INTEG_WIDTH:0]   integ_add;
  logic signed [INTEG_WIDTH-1:0] integ_sat, integ_win, clamp_pos;
  logic signed [DER_W-1:0]       deriv_c;
  logic                          invalid_c, integ_ok;

  assign invalid_c = meas_r < min_valid_r;
  assign err_c     = ERR_W'(tgt_r) - ERR_W'(meas_r);
  assign abs_err   = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
  assign integ_ok  = (INTEG_WIDTH'(integ_limit_r) > INTEG_WIDTH'(abs_err))
                     && (integ_limit_r != '0) && (integ_sum_r < INTEG_WINDUP_MAX);
  assign integ_add = (INTEG_WIDTH+1)'(integ_sum_r) + (INTEG_WIDTH+1)'(err_c);
  assign clamp_pos = $signed(INTEG_WIDTH'(integ_clamp_r));

  always_comb begin
    // saturate to 32 bits
    if (integ_add[INTEG_WIDTH] != integ_add[INTEG_WIDTH-1]) begin
      integ_sat = integ_add[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                         : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    end else begin
      integ_sat = integ_add[INTEG_WIDTH-1:0];
    end
    integ_win = integ_ok ? integ_sat : '0;
    // optional symmetric clamp
    integ_new = integ_win;
    if (integ_clamp_r != '0) begin
      if (integ_win > clamp_pos)       integ_new = clamp_pos;
      else if (integ_win < -clamp_pos) integ_new = -clamp_pos;
    end
  end

  assign deriv_c = DER_W'(err_c) - DER_W'(prev_err_r);

  always_comb begin
    integ_nxt    = integ_sum_r;
    prev_err_nxt = prev_err_r;
    if (adv1) begin
      if (clr_r) begin
        integ_nxt    = '0;
        prev_err_nxt = '0;
      end else if (!invalid_c) begin
        integ_nxt    = integ_new;
        prev_err_nxt = err_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_sum_r <= '0;
      prev_err_r  <= '0;
    end else begin
      integ_sum_r <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
    end
  end

  // Stage 2 register: operands are zeroed for clear and invalid beats,
  // which makes the drive and limit flag come out as zero
  logic signed [ERR_W-1:0]       err2_r;
  logic signed [INTEG_WIDTH-1:0] integ2_r;
  logic signed [DER_W-1:0]       deriv2_r;
  logic                          inv2_r;
  logic                          use_c;

  assign use_c = !clr_r && !invalid_c;

  always_ff @(posedge clk) begin
    if (load2) begin
      err2_r   <= use_c ? err_c : '0;
      integ2_r <= use_c ? integ_new : '0;
      deriv2_r <= use_c ? deriv_c : '0;
      inv2_r   <= !clr_r && invalid_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: gain multipliers
  logic signed [PP_W-1:0] prod_p_r;
  logic signed [PI_W-1:0] prod_i_r;
  logic signed [PD_W-1:0] prod_d_r;
  logic                   inv3_r;

  always_ff @(posedge clk) begin
    if (load3) begin
      prod_p_r <= PP_W'(err2_r * $signed({1'b0, gain_p_r}));
      prod_i_r <= PI_W'(integ2_r * $signed({1'b0, gain_i_r}));
      prod_d_r <= PD_W'(deriv2_r * $signed({1'b0, gain_d_r}));
      inv3_r   <= inv2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: sum, truncate toward zero, minimum drive, clamp, saturate
  logic signed [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0]        sum_mag;
  logic [MAG_W-1:0]        mag, mag_min, mag_clamp, sat_lim;
  logic [SAT_W-1:0]        mag_fin;
  logic                    neg, limited_c;
  logic [DRIVE_WIDTH-1:0]  drive_c;

  assign sum_c   = SUM_W'(prod_p_r) + SUM_W'(prod_i_r) - SUM_W'(prod_d_r);
  assign sum_mag = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
  assign mag     = MAG_W'(sum_mag >> GAIN_FRAC_BITS);
  assign neg     = sum_c[SUM_W-1] && (mag != '0);
  assign sat_lim = neg ? MAG_W'(2**(DRIVE_WIDTH-1)) : MAG_W'(2**(DRIVE_WIDTH-1) - 1);

  always_comb begin
    limited_c = 1'b0;
    // small nonzero outputs are raised to the minimum drive magnitude
    if (mag > MAG_W'(min_speed_r) || mag == '0) mag_min = mag;
    else                                           mag_min = MAG_W'(min_speed_r);
    // optional symmetric output clamp
    mag_clamp = mag_min;
    if (output_clamp_r != '0 && mag_min > MAG_W'(output_clamp_r)) begin
      mag_clamp = MAG_W'(output_clamp_r);
      limited_c = 1'b1;
    end
    // 16-bit saturation
    if (mag_clamp > sat_lim) begin
      mag_fin   = SAT_W'(sat_lim);
      limited_c = 1'b1;
    end else begin
      mag_fin = SAT_W'(mag_clamp);
    end
    drive_c = neg ? DRIVE_WIDTH'(-mag_fin) : DRIVE_WIDTH'(mag_fin);
  end

  logic signed [DRIVE_WIDTH-1:0] drive_r;
  logic                          inv_o_r, limited_r;

  always_ff @(posedge clk) begin
    if (load_o) begin
      drive_r   <= drive_c;
      inv_o_r   <= inv3_r;
      limited_r <= limited_c;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.sensor_invalid = inv_o_r;
  assign out_ch.output_limited = limited_r;

endmodule

`default_nettype wire
